/* rtl/core/pairwise_distance_matrix_unit_macros.svh */
// Assertion macros for the pairwise distance matrix unit.
`ifndef PAIRWISE_DISTANCE_MATRIX_UNIT_MACROS_SVH
`define PAIRWISE_DISTANCE_MATRIX_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PDM_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdm check failed");
`define PDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdm check failed");
`else
`define PDM_ASSERT_SAME(label, clk, rst, ante, cons)
`define PDM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/pdm_pkg.sv */
// Package: sizes, payload types and sequencer states of the distance matrix unit.
package pdm_pkg;
  localparam int MAX_ATOMS  = 64;
  localparam int COORD_BITS = 24;
  localparam int ADDR_W     = $clog2(MAX_ATOMS);
  localparam int CNT_W      = $clog2(MAX_ATOMS + 1);
  localparam int IDX_W      = 6;
  localparam int DIST_W     = 25;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int SUM_W      = 2 * COORD_BITS + 2;
  localparam int ROOT_W     = COORD_BITS + 1;

  typedef struct packed {
    logic                         start_molecule;
    logic signed [COORD_BITS-1:0] x_coord;
    logic signed [COORD_BITS-1:0] y_coord;
    logic signed [COORD_BITS-1:0] z_coord;
  } atom_t;

  typedef struct packed {
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;
    logic [DIST_W-1:0] distance;
    logic              last_of_row;
    logic              overflow;
  } entry_t;

  // offset-binary coordinates as held in the atom store
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
  } coords_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic             last_of_row;
    logic             overflow;
  } meta_t;

  typedef enum logic {
    ST_IDLE,
    ST_ISSUE
  } state_t;

  function automatic logic [COORD_BITS-1:0] abs_diff(logic [COORD_BITS-1:0] a,
                                                     logic [COORD_BITS-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction
endpackage

/* rtl/core/pairwise_distance_matrix_unit.sv */
// Top level: atom store, pair sequencer and pipelined distance datapath.
//
//   channel  signals                          direction  contents
//   atom     atom_valid / atom_ready / atom   in         start flag, x, y, z
//   entry    entry_valid / entry_ready / entry out       row, col, distance, flags
//
// An atom at index i is accepted, then issues one entry per cycle while the entry
// side does not stall (i pairs and the diagonal), read from the atom store. A dropped
// atom issues a single overflow entry. Results pass the datapath and root stages.
// Reset clears the count and the pipeline; store contents stay undefined.
// A stall on the entry side freezes the whole pipeline and the sequencer while it issues.
`include "pairwise_distance_matrix_unit_macros.svh"
module pairwise_distance_matrix_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            atom_valid,
  output logic            atom_ready,
  input  pdm_pkg::atom_t  atom,
  output logic            entry_valid,
  input  logic            entry_ready,
  output pdm_pkg::entry_t entry
);
  localparam int C = pdm_pkg::COORD_BITS;

  pdm_pkg::coords_t mem [pdm_pkg::MAX_ATOMS];

  pdm_pkg::state_t            state, state_next;
  logic [pdm_pkg::CNT_W-1:0]  count;
  logic [pdm_pkg::ADDR_W-1:0] row, col;
  logic                       ovf;
  pdm_pkg::coords_t           cur;

  logic                       adv, accept, done, wr_en, iss_valid;
  logic [pdm_pkg::CNT_W-1:0]  count_eff;
  pdm_pkg::meta_t             iss_meta;

  assign adv       = !entry_valid || entry_ready;
  assign accept    = atom_valid && atom_ready;
  assign count_eff = atom.start_molecule ? '0 : count;
  assign done      = ovf || (col == row);
  assign wr_en     = iss_valid && adv && done && !ovf;

  always_comb begin
    state_next = state;
    unique case (state)
      pdm_pkg::ST_IDLE:  if (accept) state_next = pdm_pkg::ST_ISSUE;
      pdm_pkg::ST_ISSUE: if (adv && done) state_next = pdm_pkg::ST_IDLE;
      default:           state_next = pdm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    atom_ready = (state == pdm_pkg::ST_IDLE);
    iss_valid  = (state == pdm_pkg::ST_ISSUE);
    iss_meta.row_index   = ovf ? '0 : pdm_pkg::IDX_W'(row);
    iss_meta.col_index   = ovf ? '0 : pdm_pkg::IDX_W'(col);
    iss_meta.last_of_row = !ovf && (col == row);
    iss_meta.overflow    = ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdm_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) count <= count_eff;
      else if (wr_en) count <= pdm_pkg::CNT_W'(row) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ovf   <= (count_eff == pdm_pkg::CNT_W'(pdm_pkg::MAX_ATOMS));
      row   <= count_eff[pdm_pkg::ADDR_W-1:0];
      col   <= '0;
      cur.x <= {~atom.x_coord[C-1], atom.x_coord[C-2:0]};
      cur.y <= {~atom.y_coord[C-1], atom.y_coord[C-2:0]};
      cur.z <= {~atom.z_coord[C-1], atom.z_coord[C-2:0]};
    end else if (iss_valid && adv && !done) begin
      col <= col + 1'b1;
    end
  end

  // atom store: one read per issued entry, write of the new atom after its row
  pdm_pkg::coords_t rd_q;
  always_ff @(posedge clk) begin
    if (wr_en) mem[row] <= cur;
    if (adv) rd_q <= mem[col];
  end

  // stage 1: read data arrives; stage 2: differences; 3: squares; 4: sum
  logic                  s1_v, s2_v, s3_v;
  pdm_pkg::meta_t        s1_m, s2_m, s3_m;
  pdm_pkg::coords_t      s1_cur, s2_d;
  logic [pdm_pkg::SQ_W-1:0] s3_x, s3_y, s3_z;

  logic                       pv [pdm_pkg::ROOT_W+1];
  pdm_pkg::meta_t             pm [pdm_pkg::ROOT_W+1];
  logic [pdm_pkg::SUM_W-1:0]  prem [pdm_pkg::ROOT_W+1];
  logic [pdm_pkg::ROOT_W-1:0] proot [pdm_pkg::ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
      pv[0] <= 1'b0;
    end else if (adv) begin
      s1_v  <= iss_valid;
      s2_v  <= s1_v;
      s3_v  <= s2_v;
      pv[0] <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_m     <= iss_meta;
      s1_cur   <= cur;
      s2_m     <= s1_m;
      s2_d.x   <= pdm_pkg::abs_diff(s1_cur.x, rd_q.x);
      s2_d.y   <= pdm_pkg::abs_diff(s1_cur.y, rd_q.y);
      s2_d.z   <= pdm_pkg::abs_diff(s1_cur.z, rd_q.z);
      s3_m     <= s2_m;
      s3_x     <= pdm_pkg::SQ_W'(s2_d.x) * pdm_pkg::SQ_W'(s2_d.x);
      s3_y     <= pdm_pkg::SQ_W'(s2_d.y) * pdm_pkg::SQ_W'(s2_d.y);
      s3_z     <= pdm_pkg::SQ_W'(s2_d.z) * pdm_pkg::SQ_W'(s2_d.z);
      pm[0]    <= s3_m;
      prem[0]  <= pdm_pkg::SUM_W'(s3_x) + pdm_pkg::SUM_W'(s3_y) + pdm_pkg::SUM_W'(s3_z);
      proot[0] <= '0;
    end
  end

  // digit-by-digit square root, one root bit per stage, MSB first
  for (genvar k = 0; k < pdm_pkg::ROOT_W; k++) begin : g_sqrt
    localparam int B = pdm_pkg::ROOT_W - 1 - k;
    logic [pdm_pkg::SUM_W-1:0] trial;
    logic                      take;
    assign trial = (pdm_pkg::SUM_W'(proot[k]) << (B + 1))
                 | (pdm_pkg::SUM_W'(1) << (2 * B));
    assign take  = (prem[k] >= trial);
    always_ff @(posedge clk) begin
      if (rst) pv[k+1] <= 1'b0;
      else if (adv) pv[k+1] <= pv[k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        pm[k+1]    <= pm[k];
        prem[k+1]  <= take ? prem[k] - trial : prem[k];
        proot[k+1] <= proot[k] | (take ? (pdm_pkg::ROOT_W'(1) << B) : '0);
      end
    end
  end

  logic [pdm_pkg::ROOT_W+pdm_pkg::DIST_W-1:0] root_ext, dmax_ext;
  logic [pdm_pkg::DIST_W-1:0]                 dist_sat;
  logic                                       zero_dist;
  assign root_ext  = {pdm_pkg::DIST_W'(0), proot[pdm_pkg::ROOT_W]};
  assign dmax_ext  = {pdm_pkg::ROOT_W'(0), {pdm_pkg::DIST_W{1'b1}}};
  assign zero_dist = pm[pdm_pkg::ROOT_W].last_of_row || pm[pdm_pkg::ROOT_W].overflow;
  assign dist_sat  = (root_ext > dmax_ext) ? {pdm_pkg::DIST_W{1'b1}}
                                           : pdm_pkg::DIST_W'(root_ext);

  always_ff @(posedge clk) begin
    if (rst) entry_valid <= 1'b0;
    else if (adv) entry_valid <= pv[pdm_pkg::ROOT_W];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      entry.row_index   <= pm[pdm_pkg::ROOT_W].row_index;
      entry.col_index   <= pm[pdm_pkg::ROOT_W].col_index;
      entry.last_of_row <= pm[pdm_pkg::ROOT_W].last_of_row;
      entry.overflow    <= pm[pdm_pkg::ROOT_W].overflow;
      entry.distance    <= zero_dist ? '0 : dist_sat;
    end
  end

  `PDM_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= pdm_pkg::CNT_W'(pdm_pkg::MAX_ATOMS))
  `PDM_ASSERT_NEXT(a_count_after_write, clk, rst, wr_en, count == pdm_pkg::CNT_W'($past(row)) + 1'b1)
  `PDM_ASSERT_SAME(a_ovf_fields, clk, rst, entry_valid && entry.overflow, entry.row_index == '0 && entry.col_index == '0 && !entry.last_of_row)
  `PDM_ASSERT_SAME(a_no_issue_idle, clk, rst, atom_ready, !iss_valid && !wr_en)
endmodule

/* dv/pairwise_distance_matrix_unit_tb.sv */
// Testbench for the pairwise distance matrix unit: directed and random atoms, self-checking.
module pairwise_distance_matrix_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = pdm_pkg::ROOT_W + 20;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic atom_valid = 1'b0;
  logic atom_ready;
  pdm_pkg::atom_t atom = '0;
  logic entry_valid;
  logic entry_ready = 1'b0;
  pdm_pkg::entry_t entry;

  // model copy of the atom store, offset binary
  pdm_pkg::coords_t atoms_held [pdm_pkg::MAX_ATOMS];
  int unsigned atoms_stored;
  pdm_pkg::entry_t expected_entries [$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;
  bit failed;

  always #5 clk = ~clk;

  pairwise_distance_matrix_unit dut (
    .clk(clk), .rst(rst),
    .atom_valid(atom_valid), .atom_ready(atom_ready), .atom(atom),
    .entry_valid(entry_valid), .entry_ready(entry_ready), .entry(entry)
  );

  function automatic logic [pdm_pkg::COORD_BITS-1:0] to_offset(
      logic [pdm_pkg::COORD_BITS-1:0] v);
    return {~v[pdm_pkg::COORD_BITS-1], v[pdm_pkg::COORD_BITS-2:0]};
  endfunction

  function automatic logic [pdm_pkg::DIST_W-1:0] pair_distance(pdm_pkg::coords_t p,
                                                               pdm_pkg::coords_t q);
    logic [63:0] sum;
    logic [63:0] d;
    logic [63:0] root;
    logic [63:0] trial;
    sum = 0;
    d = (p.x > q.x) ? p.x - q.x : q.x - p.x;
    sum += d * d;
    d = (p.y > q.y) ? p.y - q.y : q.y - p.y;
    sum += d * d;
    d = (p.z > q.z) ? p.z - q.z : q.z - p.z;
    sum += d * d;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sum) root = trial;
    end
    return (root > 64'h1FF_FFFF) ? 25'h1FF_FFFF : root[pdm_pkg::DIST_W-1:0];
  endfunction

  // derive the row of entries an accepted atom causes
  function automatic void predict_row(pdm_pkg::atom_t a);
    pdm_pkg::coords_t cur;
    pdm_pkg::entry_t e;
    if (a.start_molecule) atoms_stored = 0;
    if (atoms_stored >= pdm_pkg::MAX_ATOMS) begin
      e = '0;
      e.overflow = 1'b1;
      expected_entries.push_back(e);
      return;
    end
    cur.x = to_offset(a.x_coord);
    cur.y = to_offset(a.y_coord);
    cur.z = to_offset(a.z_coord);
    for (int j = 0; j < atoms_stored; j++) begin
      e = '0;
      e.row_index = atoms_stored[pdm_pkg::IDX_W-1:0];
      e.col_index = j[pdm_pkg::IDX_W-1:0];
      e.distance = pair_distance(cur, atoms_held[j]);
      expected_entries.push_back(e);
    end
    e = '0;
    e.row_index = atoms_stored[pdm_pkg::IDX_W-1:0];
    e.col_index = atoms_stored[pdm_pkg::IDX_W-1:0];
    e.last_of_row = 1'b1;
    expected_entries.push_back(e);
    atoms_held[atoms_stored] = cur;
    atoms_stored++;
  endfunction

  // valid stays high after an accept so the next item can follow directly;
  // it drops only for idle gaps and in wait_drained
  task automatic send_atom(logic start, logic [pdm_pkg::COORD_BITS-1:0] x,
                           logic [pdm_pkg::COORD_BITS-1:0] y,
                           logic [pdm_pkg::COORD_BITS-1:0] z);
    pdm_pkg::atom_t a;
    int unsigned idle;
    a.start_molecule = start;
    a.x_coord = x;
    a.y_coord = y;
    a.z_coord = z;
    idle = 0;
    while ($urandom_range(99) < send_idle_pct) idle++;
    if (idle != 0) begin
      atom_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    atom_valid <= 1'b1;
    atom <= a;
    @(posedge clk);
    while (!atom_ready) @(posedge clk);
    predict_row(a);
  endtask

  task automatic wait_drained();
    atom_valid <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [pdm_pkg::COORD_BITS-1:0] random_coord();
    case ($urandom_range(5))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return pdm_pkg::COORD_BITS'($urandom_range(8191) - 4096);
      default: return pdm_pkg::COORD_BITS'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    entry_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && entry_valid && entry_ready) begin
      if (expected_entries.size() == 0) begin
        $error("unexpected entry row %0d col %0d", entry.row_index, entry.col_index);
        failed = 1'b1;
      end else begin
        pdm_pkg::entry_t e;
        e = expected_entries.pop_front();
        if (entry.row_index !== e.row_index) begin
          $error("row_index expected %0d actual %0d", e.row_index, entry.row_index);
          failed = 1'b1;
        end
        if (entry.col_index !== e.col_index) begin
          $error("col_index expected %0d actual %0d", e.col_index, entry.col_index);
          failed = 1'b1;
        end
        if (entry.distance !== e.distance) begin
          $error("distance expected %0d actual %0d", e.distance, entry.distance);
          failed = 1'b1;
        end
        if (entry.last_of_row !== e.last_of_row) begin
          $error("last_of_row expected %0d actual %0d", e.last_of_row, entry.last_of_row);
          failed = 1'b1;
        end
        if (entry.overflow !== e.overflow) begin
          $error("overflow expected %0d actual %0d", e.overflow, entry.overflow);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (atom_valid && atom_ready) || (entry_valid && entry_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // extremes, zero distance, full-scale distance and a short molecule
  task automatic test_directed();
    send_atom(1'b1, 24'h000000, 24'h000000, 24'h000000);
    send_atom(1'b0, 24'h000000, 24'h000000, 24'h000000);
    send_atom(1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    send_atom(1'b0, 24'h800000, 24'h800000, 24'h800000);
    send_atom(1'b0, 24'h001000, 24'hFFF000, 24'h000000);
    send_atom(1'b0, 24'h800000, 24'h7FFFFF, 24'h800000);
    send_atom(1'b0, 24'hFFFFFF, 24'h000001, 24'h555555);
    send_atom(1'b0, 24'hAAAAAA, 24'h555555, 24'hAAAAAA);
    send_atom(1'b1, 24'h123456, 24'hEDCBA9, 24'h000FFF);
    send_atom(1'b1, 24'h000003, 24'h000004, 24'h000000);
    send_atom(1'b0, 24'h000000, 24'h000000, 24'h000000);
  endtask

  // fill to capacity, then atoms past it are dropped
  task automatic test_capacity();
    send_atom(1'b1, random_coord(), random_coord(), random_coord());
    for (int k = 1; k < pdm_pkg::MAX_ATOMS + 3; k++)
      send_atom(1'b0, random_coord(), random_coord(), random_coord());
    wait_drained();
    send_atom(1'b1, 24'h7FFFFF, 24'h800000, 24'h000000);
  endtask

  // molecules of random size with random coordinates
  task automatic test_random(int unsigned n_atoms);
    int unsigned left;
    left = n_atoms;
    while (left > 0) begin
      send_atom($urandom_range(7) == 0, random_coord(), random_coord(), random_coord());
      left--;
    end
  endtask

  initial begin
    failed = 1'b0;
    atoms_stored = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_capacity();
    wait_drained();
    send_idle_pct = 49;
    test_random(70);
    send_idle_pct = 0;
    recv_stall_pct = 49;
    test_random(70);
    send_idle_pct = 9;
    recv_stall_pct = 9;
    test_random(70);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(70);
    wait_drained();
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
